/* sv/thread_priority_queue_macros.svh */
// ----------------------------------------------------------------------------
// Thread priority queue assertion macros
// Concurrent assertion wrappers shared by the queue's modules; they compile
// to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef THREAD_PRIORITY_QUEUE_MACROS_SVH
`define THREAD_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define TPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define TPQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define TPQ_ASSERT(label, clk, rst_n, prop, msg)

`define TPQ_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* sv/tpq_pkg.sv */
// ----------------------------------------------------------------------------
// Thread priority queue package
// Field widths, command and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package tpq_pkg;

    // Widths of the word fields on the ports.
    localparam int CMD_W    = 3;
    localparam int ID_W     = 16;
    localparam int PRI_W    = 8;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEXT     = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the incoming word and compare it against all slots
        logic select;   // isolate the first matching slot
        logic apply;    // update the slots and load the result register
    } tpq_ctrl_t;

endpackage

/* sv/tpq_ctrl.sv */
// ----------------------------------------------------------------------------
// Thread priority queue controller
// Sequences compare, select and apply for one command word at a time and
// owns the result valid flag.
// ----------------------------------------------------------------------------
`include "thread_priority_queue_macros.svh"

module tpq_ctrl
    import tpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output tpq_ctrl_t ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEL,
        S_ACT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready     = (state_reg == S_IDLE);
    assign ctrl.load    = in_valid && in_ready;
    assign ctrl.select  = (state_reg == S_SEL);
    assign ctrl.apply   = (state_reg == S_ACT) && (!out_valid_reg || out_ready);
    assign out_valid    = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.load)
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                state_next = S_ACT;
            end
            S_ACT:
            begin
                if (ctrl.apply)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TPQ_ASSERT(a_load_leaves_idle, clk, rst_n, ctrl.load |=> (state_reg == S_SEL), "accepted word did not start the select step")
    `TPQ_ASSERT(a_apply_sets_valid, clk, rst_n, ctrl.apply |=> out_valid_reg, "applied command produced no result word")
    `TPQ_ASSERT(a_result_held, clk, rst_n, (out_valid_reg && !out_ready) |=> out_valid_reg, "result word dropped before it was taken")

endmodule

/* sv/tpq_datapath.sv */
// ----------------------------------------------------------------------------
// Thread priority queue datapath
// Sorted slot array with per-slot compare, first-match isolation, shift
// insert and shift delete, and the result register.
// ----------------------------------------------------------------------------
`include "thread_priority_queue_macros.svh"

module tpq_datapath
    import tpq_pkg::*;
#(
    parameter int CAPACITY      = 16,
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tpq_ctrl_t           ctrl,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [ID_W-1:0]     thread_id,
    input  logic [PRI_W-1:0]    priority_req,
    output logic                found,
    output logic [PRI_W-1:0]    found_priority,
    output logic [ID_W-1:0]     next_id,
    output logic [COUNT_W-1:0]  entry_count,
    output logic [STATUS_W-1:0] status
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam logic [OCC_W-1:0] CAP = OCC_W'(CAPACITY);

    // Slot storage, kept in descending priority order from slot 0.
    logic [ID_BITS-1:0]       slot_id_reg   [CAPACITY];
    logic [PRIORITY_BITS-1:0] slot_pri_reg  [CAPACITY];
    logic [ID_BITS-1:0]       slot_id_next  [CAPACITY];
    logic [PRIORITY_BITS-1:0] slot_pri_next [CAPACITY];
    logic [ID_BITS-1:0]       succ_id       [CAPACITY];

    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;

    // Captured command word.
    logic [CMD_W-1:0]         cmd_reg;
    logic [ID_BITS-1:0]       id_reg;
    logic [PRIORITY_BITS-1:0] pri_reg;
    logic [ID_BITS-1:0]       id_in;
    logic [PRIORITY_BITS-1:0] pri_in;

    // Per-slot compare results and their first-match forms.
    logic [CAPACITY-1:0]      match_reg;
    logic [CAPACITY-1:0]      match_next;
    logic [CAPACITY-1:0]      ins_reg;
    logic [CAPACITY-1:0]      ins_next;
    logic [CAPACITY-1:0]      ins_prev;
    logic [CAPACITY-1:0]      first_reg;
    logic [CAPACITY-1:0]      first_next;
    logic [CAPACITY-1:0]      after_reg;
    logic [CAPACITY-1:0]      after_next;
    logic [CAPACITY-1:0]      match_dec;
    logic                     head_ins;

    // Result word.
    logic                     found_reg;
    logic                     found_next;
    logic [PRI_W-1:0]         fpri_reg;
    logic [PRI_W-1:0]         fpri_next;
    logic [ID_W-1:0]          nid_reg;
    logic [ID_W-1:0]          nid_next;
    logic [COUNT_W-1:0]       count_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;

    logic [PRIORITY_BITS-1:0] fpri_sel;
    logic [ID_BITS-1:0]       nid_sel;
    logic                     any_match;
    logic                     do_ins;
    logic                     do_del;

    assign id_in  = ID_BITS'(thread_id);
    assign pri_in = PRIORITY_BITS'(priority_req);

    // The new word goes to the head when its priority is at least the head's;
    // otherwise slots with a strictly lower priority, and the free slots, move.
    assign head_ins = (occ_reg == '0) || (pri_in >= slot_pri_reg[0]);

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_next[i] = (OCC_W'(i) < occ_reg) && (slot_id_reg[i] == id_in);
            ins_next[i]   = head_ins || (OCC_W'(i) >= occ_reg) || (slot_pri_reg[i] < pri_in);
        end
    end

    // Lowest set bit of the match vector, and every slot from it upward.
    assign match_dec  = match_reg - CAPACITY'(1);
    assign first_next = match_reg & ~match_dec;
    assign after_next = ~(match_reg ^ match_dec) | first_next;

    genvar g;
    for (g = 0; g < CAPACITY; g++)
    begin : g_succ
        if (g < CAPACITY - 1)
        begin : g_mid
            assign succ_id[g] = (OCC_W'(g + 1) < occ_reg) ? slot_id_reg[g + 1] : slot_id_reg[0];
        end
        else
        begin : g_last
            assign succ_id[g] = slot_id_reg[0];
        end
    end

    always_comb
    begin
        fpri_sel = '0;
        nid_sel  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_reg[i])
            begin
                fpri_sel = fpri_sel | slot_pri_reg[i];
                nid_sel  = nid_sel | succ_id[i];
            end
        end
    end

    assign any_match = |first_reg;

    always_comb
    begin
        found_next  = 1'b0;
        fpri_next   = '0;
        nid_next    = '0;
        status_next = ST_OK;
        occ_next    = occ_reg;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        unique case (cmd_reg) inside
            CMD_INSERT:
            begin
                if (occ_reg >= CAP)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_ins   = 1'b1;
                    occ_next = occ_reg + OCC_W'(1);
                end
            end
            CMD_DELETE, CMD_CONTAINS, CMD_FIND, CMD_NEXT:
            begin
                if (occ_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!any_match)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    found_next = 1'b1;
                    fpri_next  = PRI_W'(fpri_sel);
                    if (cmd_reg == CMD_DELETE)
                    begin
                        do_del   = 1'b1;
                        occ_next = occ_reg - OCC_W'(1);
                    end
                    else
                    begin
                        nid_next = ID_W'(nid_sel);
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Slot moves: an insert shifts the tail up by one from the insert point,
    // a delete shifts it down by one onto the removed slot.
    assign ins_prev = {ins_reg[CAPACITY-2:0], 1'b0};

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_id_next[i]  = slot_id_reg[i];
            slot_pri_next[i] = slot_pri_reg[i];
        end
        for (int i = 1; i < CAPACITY; i++)
        begin
            if (do_ins && ins_reg[i] && ins_prev[i])
            begin
                slot_id_next[i]  = slot_id_reg[i - 1];
                slot_pri_next[i] = slot_pri_reg[i - 1];
            end
        end
        for (int i = 0; i < CAPACITY - 1; i++)
        begin
            if (do_del && after_reg[i])
            begin
                slot_id_next[i]  = slot_id_reg[i + 1];
                slot_pri_next[i] = slot_pri_reg[i + 1];
            end
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (do_ins && ins_reg[i] && !ins_prev[i])
            begin
                slot_id_next[i]  = id_reg;
                slot_pri_next[i] = pri_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.apply)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                slot_id_reg[i]  <= slot_id_next[i];
                slot_pri_reg[i] <= slot_pri_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= cmd;
            id_reg    <= id_in;
            pri_reg   <= pri_in;
            match_reg <= match_next;
            ins_reg   <= ins_next;
        end
        if (ctrl.select)
        begin
            first_reg <= first_next;
            after_reg <= after_next;
        end
        if (ctrl.apply)
        begin
            found_reg  <= found_next;
            fpri_reg   <= fpri_next;
            nid_reg    <= nid_next;
            count_reg  <= COUNT_W'(occ_next);
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (ctrl.apply)
        begin
            occ_reg <= occ_next;
        end
    end

    assign found          = found_reg;
    assign found_priority = fpri_reg;
    assign next_id        = nid_reg;
    assign entry_count    = count_reg;
    assign status         = status_reg;

    `TPQ_ASSERT_NEVER(a_occ_bound, clk, rst_n, occ_reg > CAP, "occupancy above capacity")
    `TPQ_ASSERT(a_first_onehot, clk, rst_n, ctrl.apply |-> $onehot0(first_reg), "more than one first match")
    `TPQ_ASSERT(a_insert_grows, clk, rst_n, (ctrl.apply && cmd_reg == CMD_INSERT && occ_reg < CAP) |=> (occ_reg == $past(occ_reg) + OCC_W'(1)), "insert did not add one entry")

endmodule

/* sv/thread_priority_queue.sv */
// ----------------------------------------------------------------------------
// Thread priority queue
// Fixed-capacity ready queue of thread ids in descending priority order.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY thread ids with their priorities, head first
// and largest priority served first; the entry after the last one is the head
// again. Each accepted command word gives exactly one result word. Insert
// puts the thread at the head when its priority is at least the head's, and
// otherwise just before the first entry of strictly lower priority, or at the
// tail; a full queue reports status full and is left alone. Delete removes
// the first entry with a matching id and reports its priority. Contains, find
// and next-after-id report the first matching entry's priority and the id of
// the entry after it, wrapping to the head (a lone entry follows itself).
// An empty queue reports status empty and an unknown id status not found.
// Duplicate ids are kept; lookups and delete act on the one nearest the head.
// entry_count always gives the number of entries after the command. Command
// codes 5 to 7 change nothing and return zeros apart from entry_count.
// A command runs through capture, select and apply: the cycle in which the
// word is accepted captures it and compares it against every slot in
// parallel, the next one isolates the first matching slot, and the apply
// step then shifts the slot array and loads the result register, raising
// out_valid. A new word is accepted in the cycle after the previous result
// is loaded, so a command is not taken while the last one is in progress; a
// result that waits to be taken holds only the apply step of the next
// command, not its capture.
// ----------------------------------------------------------------------------
module thread_priority_queue
    import tpq_pkg::*;
#(
    parameter int CAPACITY      = 16,
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [ID_W-1:0]     thread_id,
    input  logic [PRI_W-1:0]    priority_req,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [PRI_W-1:0]    found_priority,
    output logic [ID_W-1:0]     next_id,
    output logic [COUNT_W-1:0]  entry_count,
    output logic [STATUS_W-1:0] status
);

    tpq_ctrl_t ctrl;

    // The controller steps each word through capture, select and apply.
    tpq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    // The datapath holds the sorted slots, the occupancy and the result word.
    tpq_datapath #(
        .CAPACITY      (CAPACITY),
        .ID_BITS       (ID_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cmd            (cmd),
        .thread_id      (thread_id),
        .priority_req   (priority_req),
        .found          (found),
        .found_priority (found_priority),
        .next_id        (next_id),
        .entry_count    (entry_count),
        .status         (status)
    );

endmodule
